// ===== rtl/range_sensor_filter_linearize_assert.svh =====
// Assertion macros shared by the range sensor filter RTL.
// Users must have clk and rst (synchronous, active high) in scope.
`ifndef RANGE_SENSOR_FILTER_LINEARIZE_ASSERT_SVH
`define RANGE_SENSOR_FILTER_LINEARIZE_ASSERT_SVH

// same-cycle implication
`define RSFL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSFL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rsfl_pkg.sv =====
// Shared types and constants for the range sensor filter and linearizer.
// No dependencies.
`default_nettype none

package rsfl_pkg;

  localparam int RAW_W    = 12;  // converter sample / filtered value
  localparam int SENSOR_W = 2;
  localparam int ACC_W    = 14;  // sum of up to four samples
  localparam int CAL_W    = 36;  // three packed 12-bit sensor values
  localparam int MASK_W   = 3;
  localparam int REG_W    = 3;   // config register index
  localparam int DQ_W     = 14;  // Q6.8 distance
  localparam int QUOT_W   = 12;  // interpolation quotient bits
  localparam int DIV_CW   = 4;   // counts QUOT_W steps
  localparam int SEG_W    = 3;

  localparam logic [REG_W-1:0] REG_CAL_POINT_0    = 3'd0;
  localparam logic [REG_W-1:0] REG_CAL_VALID_MASK = 3'd6;

  localparam logic [DQ_W-1:0] DIST_MIN_Q8 = 14'd1280;  // 5 cm
  localparam logic [DQ_W-1:0] DIST_MAX_Q8 = 14'd8960;  // 35 cm

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    logic [ACC_W-1:0]    acc;
    logic                bypass;      // read error or sensor out of range
    logic                read_error;
  } front_word_t;

  typedef struct packed {
    logic [RAW_W-1:0] filtered_raw;
    logic [DQ_W-1:0]  distance_q8;
    logic             distance_valid;
    logic             read_failed;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_SUM,
    ST_MEAN,
    ST_FILT,
    ST_SEG,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } back_state_t;

  // segment start distance, Q6.8
  function automatic logic [DQ_W-1:0] seg_base(input logic [SEG_W-1:0] idx);
    logic [DQ_W-1:0] v;
    unique case (idx)
      3'd0:    v = 14'd1280;
      3'd1:    v = 14'd2048;
      3'd2:    v = 14'd3072;
      3'd3:    v = 14'd4608;
      3'd4:    v = 14'd6400;
      default: v = 14'd1280;
    endcase
    return v;
  endfunction

  // segment distance span, Q6.8
  function automatic logic [QUOT_W-1:0] seg_step(input logic [SEG_W-1:0] idx);
    logic [QUOT_W-1:0] v;
    unique case (idx)
      3'd0:    v = 12'd768;
      3'd1:    v = 12'd1024;
      3'd2:    v = 12'd1536;
      3'd3:    v = 12'd1792;
      3'd4:    v = 12'd2560;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rsfl_fifo.sv =====
// Two-entry register queue with push/full and pop/empty sides.
// No dependencies.
`default_nettype none

module rsfl_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      dout
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop) rptr <= ~rptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= din;
  end

endmodule

`default_nettype wire

// ===== rtl/rsfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rsfl_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 24,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/rsfl_front.sv =====
// Front end: takes input words, flags bypass words, sums the oversamples
// and queues the result for the back end. Uses rsfl_pkg and rsfl_fifo.
`default_nettype none

module rsfl_front #(
  parameter int SENSORS    = 3,
  parameter int OVERSAMPLE = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [rsfl_pkg::SENSOR_W-1:0] sensor_index,
  input  wire logic [rsfl_pkg::RAW_W-1:0]    sample_a,
  input  wire logic [rsfl_pkg::RAW_W-1:0]    sample_b,
  input  wire logic [rsfl_pkg::RAW_W-1:0]    sample_c,
  input  wire logic [rsfl_pkg::RAW_W-1:0]    sample_d,
  input  wire logic                          read_error,
  output rsfl_pkg::front_word_t              word,
  output logic                               word_empty,
  input  wire logic                          word_pop
);

  logic [rsfl_pkg::RAW_W-1:0] samples [4];
  logic [rsfl_pkg::ACC_W-1:0] acc;
  rsfl_pkg::front_word_t      in_word;

  assign samples[0] = sample_a;
  assign samples[1] = sample_b;
  assign samples[2] = sample_c;
  assign samples[3] = sample_d;

  always_comb begin
    acc = '0;
    for (int k = 0; k < OVERSAMPLE; k++) begin
      acc = acc + rsfl_pkg::ACC_W'(samples[k]);
    end
  end

  always_comb begin
    in_word.sensor     = sensor_index;
    in_word.acc        = acc;
    in_word.read_error = read_error;
    in_word.bypass     = read_error ||
                         (sensor_index >= rsfl_pkg::SENSOR_W'(SENSORS));
  end

  rsfl_fifo #(
    .WIDTH($bits(rsfl_pkg::front_word_t))
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .din  (in_word),
    .pop  (word_pop),
    .empty(word_empty),
    .dout (word)
  );

endmodule

`default_nettype wire

// ===== rtl/rsfl_back.sv =====
// Back end: sequencer that averages, updates the per-sensor ring, takes the
// window mean and interpolates the calibration curve with a serial divider.
// Uses rsfl_pkg, rsfl_ram and the assertion macro header.
`default_nettype none
`include "range_sensor_filter_linearize_assert.svh"

module rsfl_back #(
  parameter int SENSORS    = 3,
  parameter int WINDOW     = 8,
  parameter int CAL_POINTS = 6,
  parameter int OVERSAMPLE = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [rsfl_pkg::REG_W-1:0] cfg_index,
  input  wire logic [rsfl_pkg::CAL_W-1:0] cfg_data,
  input  wire rsfl_pkg::front_word_t      in_word,
  input  wire logic                       in_empty,
  output logic                            in_pop,
  output rsfl_pkg::result_t               out_word,
  input  wire logic                       out_full,
  output logic                            out_push
);

  localparam int RAW_W  = rsfl_pkg::RAW_W;
  localparam int QW     = rsfl_pkg::QUOT_W;
  localparam int SW     = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int PW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DEPTH  = SENSORS * WINDOW;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W  = $clog2(WINDOW * 4095 + 1);

  // divide by constant: multiply by ceil(2^K / N), exact for these ranges
  localparam int KO     = rsfl_pkg::ACC_W + $clog2(OVERSAMPLE) + 1;
  localparam int RO_W   = KO + 1;
  localparam int RO_INT = (2 ** KO + OVERSAMPLE - 1) / OVERSAMPLE;
  localparam int PO_W   = rsfl_pkg::ACC_W + RO_W;
  localparam int KW     = SUM_W + $clog2(WINDOW) + 1;
  localparam int RW_W   = KW + 1;
  localparam int RW_INT = (2 ** KW + WINDOW - 1) / WINDOW;
  localparam int PM_W   = SUM_W + RW_W;

  localparam logic [RO_W-1:0] RECIP_OS  = RO_W'(RO_INT);
  localparam logic [RW_W-1:0] RECIP_WIN = RW_W'(RW_INT);
  localparam logic [PW-1:0]   POS_LAST  = PW'(WINDOW - 1);
  localparam logic [rsfl_pkg::DIV_CW-1:0] DIV_LAST = rsfl_pkg::DIV_CW'(QW - 1);

  rsfl_pkg::back_state_t state, state_next;

  // config
  logic [rsfl_pkg::CAL_W-1:0]  cal_point [CAL_POINTS];
  logic [rsfl_pkg::MASK_W-1:0] cal_valid_mask;

  // per-sensor ring state
  logic [SUM_W-1:0]   win_sum [SENSORS];
  logic [PW-1:0]      win_pos [SENSORS];
  logic [SENSORS-1:0] wrapped;

  // item datapath
  logic [rsfl_pkg::SENSOR_W-1:0] sensor;
  logic [rsfl_pkg::ACC_W-1:0]    acc;
  logic [PO_W-1:0]               prod_avg;
  logic [SUM_W-1:0]              sum_reg;
  logic [PM_W-1:0]               prod_mean;
  rsfl_pkg::result_t             res;
  logic [rsfl_pkg::DQ_W-1:0]     base;
  logic [QW-1:0]                 step;
  logic [RAW_W-1:0]              dlt;
  logic [RAW_W-1:0]              span;
  logic [QW-1:0]                 rem;
  logic [QW-1:0]                 quo;
  logic [rsfl_pkg::DIV_CW-1:0]   div_cnt;

  logic [SW-1:0]    si;
  logic [PW-1:0]    pos_cur;
  logic [PW-1:0]    pos_next;
  logic [AW-1:0]    ram_addr;
  logic [RAW_W-1:0] ram_rdata;
  logic [RAW_W-1:0] avg;
  logic [RAW_W-1:0] old;
  logic [SUM_W-1:0] sum_new;
  logic [RAW_W-1:0] filt;
  logic             cal_ok;

  logic [RAW_W-1:0]          cal_raw [CAL_POINTS];
  logic                      seg_hit;
  logic [rsfl_pkg::SEG_W-1:0] seg_idx;
  logic [RAW_W-1:0]          seg_hi;
  logic [RAW_W-1:0]          seg_lo;

  logic [QW:0]   div_t;
  logic [QW:0]   div_diff;
  logic          div_ge;
  logic [QW-1:0] rem_next;
  logic [QW-1:0] quo_next;

  assign si       = sensor[SW-1:0];
  assign pos_cur  = win_pos[si];
  assign pos_next = (pos_cur == POS_LAST) ? '0 : PW'(pos_cur + PW'(1));
  assign ram_addr = AW'(AW'(si) * AW'(WINDOW) + AW'(pos_cur));
  assign avg      = prod_avg[KO +: RAW_W];
  assign old      = wrapped[si] ? ram_rdata : '0;
  assign sum_new  = win_sum[si] - SUM_W'(old) + SUM_W'(avg);
  assign filt     = res.filtered_raw;
  assign cal_ok   = cal_valid_mask[si];
  assign out_word = res;

  rsfl_ram #(
    .WIDTH(RAW_W),
    .DEPTH(DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (state == rsfl_pkg::ST_SUM),
    .waddr(ram_addr),
    .wdata(avg),
    .raddr(ram_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < CAL_POINTS; i++) begin
      cal_raw[i] = cal_point[i][RAW_W*si +: RAW_W];
    end
  end

  // first matching segment wins: scan from the top so lower ones override
  always_comb begin
    seg_hit = 1'b0;
    seg_idx = '0;
    seg_hi  = '0;
    seg_lo  = '0;
    for (int i = CAL_POINTS - 2; i >= 0; i--) begin
      if (filt <= cal_raw[i] && filt >= cal_raw[i+1]) begin
        seg_hit = 1'b1;
        seg_idx = rsfl_pkg::SEG_W'(i);
        seg_hi  = cal_raw[i];
        seg_lo  = cal_raw[i+1];
      end
    end
  end

  // one restoring step; remainder stays below span so QW bits hold it
  always_comb begin
    div_t    = {rem, quo[QW-1]};
    div_diff = div_t - (QW+1)'(span);
    div_ge   = (div_t >= (QW+1)'(span));
    rem_next = div_ge ? div_diff[QW-1:0] : div_t[QW-1:0];
    quo_next = {quo[QW-2:0], div_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rsfl_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_pop     = 1'b0;
    out_push   = 1'b0;
    unique case (state)
      rsfl_pkg::ST_IDLE: begin
        if (!in_empty) begin
          in_pop     = 1'b1;
          state_next = in_word.bypass ? rsfl_pkg::ST_EMIT : rsfl_pkg::ST_AVG;
        end
      end
      rsfl_pkg::ST_AVG:  state_next = rsfl_pkg::ST_SUM;
      rsfl_pkg::ST_SUM:  state_next = rsfl_pkg::ST_MEAN;
      rsfl_pkg::ST_MEAN: state_next = rsfl_pkg::ST_FILT;
      rsfl_pkg::ST_FILT: state_next = rsfl_pkg::ST_SEG;
      rsfl_pkg::ST_SEG: begin
        state_next = (cal_ok && seg_hit) ? rsfl_pkg::ST_MUL : rsfl_pkg::ST_EMIT;
      end
      rsfl_pkg::ST_MUL:  state_next = rsfl_pkg::ST_DIV;
      rsfl_pkg::ST_DIV: begin
        if (div_cnt == DIV_LAST) state_next = rsfl_pkg::ST_EMIT;
      end
      rsfl_pkg::ST_EMIT: begin
        if (!out_full) begin
          out_push   = 1'b1;
          state_next = rsfl_pkg::ST_IDLE;
        end
      end
      default: state_next = rsfl_pkg::ST_IDLE;
    endcase
  end

  // control and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CAL_POINTS; i++) cal_point[i] <= '0;
      cal_valid_mask <= '0;
      for (int s = 0; s < SENSORS; s++) begin
        win_sum[s] <= '0;
        win_pos[s] <= '0;
      end
      wrapped <= '0;
      div_cnt <= '0;
    end else begin
      if (cfg_write) begin
        for (int i = 0; i < CAL_POINTS; i++) begin
          if (cfg_index == rsfl_pkg::REG_CAL_POINT_0 + rsfl_pkg::REG_W'(i)) begin
            cal_point[i] <= cfg_data;
          end
        end
        if (cfg_index == rsfl_pkg::REG_CAL_VALID_MASK) begin
          cal_valid_mask <= cfg_data[rsfl_pkg::MASK_W-1:0];
        end
      end
      if (state == rsfl_pkg::ST_SUM) begin
        win_sum[si] <= sum_new;
        win_pos[si] <= pos_next;
        if (pos_cur == POS_LAST) wrapped[si] <= 1'b1;
      end
      if (state == rsfl_pkg::ST_MUL) div_cnt <= '0;
      else if (state == rsfl_pkg::ST_DIV) div_cnt <= div_cnt + rsfl_pkg::DIV_CW'(1);
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state)
      rsfl_pkg::ST_IDLE: begin
        if (in_pop) begin
          sensor             <= in_word.sensor;
          acc                <= in_word.acc;
          res.filtered_raw   <= '0;
          res.distance_q8    <= '0;
          res.distance_valid <= 1'b0;
          res.read_failed    <= in_word.read_error;
        end
      end
      rsfl_pkg::ST_AVG:  prod_avg  <= PO_W'(acc) * PO_W'(RECIP_OS);
      rsfl_pkg::ST_SUM:  sum_reg   <= sum_new;
      rsfl_pkg::ST_MEAN: prod_mean <= PM_W'(sum_reg) * PM_W'(RECIP_WIN);
      rsfl_pkg::ST_FILT: res.filtered_raw <= prod_mean[KW +: RAW_W];
      rsfl_pkg::ST_SEG: begin
        base <= rsfl_pkg::seg_base(seg_idx);
        step <= rsfl_pkg::seg_step(seg_idx);
        dlt  <= seg_hi - filt;
        span <= seg_hi - seg_lo;
        if (!cal_ok) begin
          res.distance_q8    <= '0;
          res.distance_valid <= 1'b0;
        end else if (seg_hit) begin
          res.distance_valid <= 1'b1;
        end else if (filt > cal_raw[0]) begin
          res.distance_q8    <= rsfl_pkg::DIST_MIN_Q8;
          res.distance_valid <= 1'b1;
        end else begin
          res.distance_q8    <= '0;
          res.distance_valid <= 1'b0;
        end
      end
      rsfl_pkg::ST_MUL: {rem, quo} <= (2*QW)'(dlt) * (2*QW)'(step);
      rsfl_pkg::ST_DIV: begin
        rem <= rem_next;
        quo <= quo_next;
        if (div_cnt == DIV_LAST) begin
          // zero-width segment: fraction is zero
          res.distance_q8 <= base + ((span == '0) ? '0 : rsfl_pkg::DQ_W'(quo_next));
        end
      end
      default: ;
    endcase
  end

  `RSFL_ASSERT_IMP(a_fail_clears, out_push && out_word.read_failed,
    out_word.filtered_raw == '0 && !out_word.distance_valid, "read error word carries data")
  `RSFL_ASSERT_IMP(a_invalid_zero, out_push && !out_word.distance_valid,
    out_word.distance_q8 == '0, "invalid distance not zero")
  `RSFL_ASSERT_IMP(a_dist_range, out_push && out_word.distance_valid,
    out_word.distance_q8 >= rsfl_pkg::DIST_MIN_Q8 &&
    out_word.distance_q8 <= rsfl_pkg::DIST_MAX_Q8, "distance outside calibrated span")
  `RSFL_ASSERT_NXT(a_emit_done, state == rsfl_pkg::ST_EMIT && !out_full,
    state == rsfl_pkg::ST_IDLE, "sequencer stuck after result push")

endmodule

`default_nettype wire

// ===== rtl/range_sensor_filter_linearize.sv =====
// A bypass word (read error or bad sensor) goes from accept straight to emit;
//   others pass the average, sum, mean, filter and segment states, interpolated
//   ones then a multiply state and the 12-step serial divider. A new word is
//   taken after the last result push; a two-word queue sits on each side.
// Reset (rst, sync): clears calibration, window sums, positions and fill flags;
//   window RAM contents are ignored until a sensor's ring has wrapped.
`default_nettype none

module range_sensor_filter_linearize #(
  parameter int SENSORS    = 3,
  parameter int WINDOW     = 8,
  parameter int CAL_POINTS = 6,
  parameter int OVERSAMPLE = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [rsfl_pkg::SENSOR_W-1:0] sensor_index,
  input  wire logic [rsfl_pkg::RAW_W-1:0]    sample_a,
  input  wire logic [rsfl_pkg::RAW_W-1:0]    sample_b,
  input  wire logic [rsfl_pkg::RAW_W-1:0]    sample_c,
  input  wire logic [rsfl_pkg::RAW_W-1:0]    sample_d,
  input  wire logic                          read_error,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [rsfl_pkg::RAW_W-1:0]         filtered_raw,
  output logic [rsfl_pkg::DQ_W-1:0]          distance_q8,
  output logic                               distance_valid,
  output logic                               read_failed,
  input  wire logic                          cfg_write,
  input  wire logic [rsfl_pkg::REG_W-1:0]    cfg_index,
  input  wire logic [rsfl_pkg::CAL_W-1:0]    cfg_data
);

  rsfl_pkg::front_word_t front_word;
  logic                  front_empty;
  logic                  front_pop;
  rsfl_pkg::result_t     back_word;
  logic                  back_push;
  logic                  res_full;
  rsfl_pkg::result_t     res_word;

  rsfl_front #(
    .SENSORS   (SENSORS),
    .OVERSAMPLE(OVERSAMPLE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .sensor_index(sensor_index),
    .sample_a    (sample_a),
    .sample_b    (sample_b),
    .sample_c    (sample_c),
    .sample_d    (sample_d),
    .read_error  (read_error),
    .word        (front_word),
    .word_empty  (front_empty),
    .word_pop    (front_pop)
  );

  rsfl_back #(
    .SENSORS   (SENSORS),
    .WINDOW    (WINDOW),
    .CAL_POINTS(CAL_POINTS),
    .OVERSAMPLE(OVERSAMPLE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_word  (front_word),
    .in_empty (front_empty),
    .in_pop   (front_pop),
    .out_word (back_word),
    .out_full (res_full),
    .out_push (back_push)
  );

  rsfl_fifo #(
    .WIDTH($bits(rsfl_pkg::result_t))
  ) u_result_queue (
    .clk  (clk),
    .rst  (rst),
    .push (back_push),
    .full (res_full),
    .din  (back_word),
    .pop  (pop),
    .empty(empty),
    .dout (res_word)
  );

  assign filtered_raw   = res_word.filtered_raw;
  assign distance_q8    = res_word.distance_q8;
  assign distance_valid = res_word.distance_valid;
  assign read_failed    = res_word.read_failed;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for range_sensor_filter_linearize: per-sensor moving average plus
// piecewise-linear distance calibration, checked word by word against an inline predictor.
// Depends on rsfl_pkg and the range_sensor_filter_linearize RTL.

module tb_top;

  localparam int N_SENSORS = 3;
  localparam int WIN_LEN = 8;
  localparam int N_POINTS = 6;
  localparam logic [rsfl_pkg::REG_W-1:0] REG_OUT_OF_RANGE = 3'd7;  // past the register list
  localparam int SETTLE_CYCLES = 30;
  localparam int STALL_CYCLES = 400;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_SHOWN = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [rsfl_pkg::SENSOR_W-1:0] sensor_index = '0;
  logic [rsfl_pkg::RAW_W-1:0] sample_a = '0;
  logic [rsfl_pkg::RAW_W-1:0] sample_b = '0;
  logic [rsfl_pkg::RAW_W-1:0] sample_c = '0;
  logic [rsfl_pkg::RAW_W-1:0] sample_d = '0;
  logic read_error = 1'b0;
  logic cfg_write = 1'b0;
  logic [rsfl_pkg::REG_W-1:0] cfg_index = '0;
  logic [rsfl_pkg::CAL_W-1:0] cfg_data = '0;
  logic full, empty, distance_valid, read_failed;
  logic [rsfl_pkg::RAW_W-1:0] filtered_raw;
  logic [rsfl_pkg::DQ_W-1:0] distance_q8;

  range_sensor_filter_linearize i_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .sensor_index(sensor_index), .sample_a(sample_a), .sample_b(sample_b),
    .sample_c(sample_c), .sample_d(sample_d), .read_error(read_error),
    .empty(empty), .pop(pop),
    .filtered_raw(filtered_raw), .distance_q8(distance_q8),
    .distance_valid(distance_valid), .read_failed(read_failed),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [rsfl_pkg::CAL_W-1:0] cal_pt [N_POINTS];
  logic [rsfl_pkg::MASK_W-1:0] cal_mask;
  logic [rsfl_pkg::RAW_W-1:0] ring [N_SENSORS][WIN_LEN];
  logic [14:0] ring_sum [N_SENSORS];
  logic [2:0] ring_pos [N_SENSORS];
  logic [rsfl_pkg::CAL_W-1:0] next_cal [N_POINTS];

  rsfl_pkg::result_t readings_due [$];
  int send_idle_pct, recv_idle_pct;
  logic rx_hold = 1'b0;
  int words_sent = 0;
  int readings_checked = 0;
  int bad_readings = 0;
  int settings_used = 1;
  int cycles = 0;

  function automatic int dist_cm(input int idx);
    case (idx)
      0: return 5;
      1: return 8;
      2: return 12;
      3: return 18;
      4: return 25;
      default: return 35;
    endcase
  endfunction

  function automatic logic [rsfl_pkg::RAW_W-1:0] cal_raw_of(input int pt, input int s);
    return cal_pt[pt][12*s +: 12];
  endfunction

  function automatic void raw_to_distance(input int s, input logic [rsfl_pkg::RAW_W-1:0] raw,
                                          output logic [rsfl_pkg::DQ_W-1:0] dq,
                                          output logic ok);
    int unsigned hi, lo, rv, frac, span_q, gap_q8;
    dq = '0;
    ok = 1'b0;
    rv = 32'(raw);
    if (!cal_mask[s]) return;
    for (int i = 0; i < N_POINTS - 1; i++) begin
      hi = 32'(cal_raw_of(i, s));
      lo = 32'(cal_raw_of(i + 1, s));
      // first segment that brackets the value wins; inverted ones never match
      if (rv <= hi && rv >= lo) begin
        span_q = hi - lo;
        gap_q8 = 32'((dist_cm(i + 1) - dist_cm(i)) << 8);
        frac = (span_q == 0) ? 0 : ((hi - rv) * gap_q8) / span_q;
        dq = rsfl_pkg::DQ_W'(32'(dist_cm(i) << 8) + frac);
        ok = 1'b1;
        return;
      end
    end
    if (rv > 32'(cal_raw_of(0, s))) begin
      dq = rsfl_pkg::DQ_W'(dist_cm(0) << 8);
      ok = 1'b1;
    end
  endfunction

  function automatic rsfl_pkg::result_t filter_and_linearize(
      input logic [rsfl_pkg::SENSOR_W-1:0] s,
      input logic [rsfl_pkg::RAW_W-1:0] a, b, c, d, input logic e);
    rsfl_pkg::result_t r;
    logic [rsfl_pkg::ACC_W-1:0] acc;
    logic [rsfl_pkg::RAW_W-1:0] avg, filt;
    logic [2:0] p;
    logic [rsfl_pkg::DQ_W-1:0] dq;
    logic ok;
    r = '0;
    r.read_failed = e;
    if (e || s >= N_SENSORS) return r;
    acc = rsfl_pkg::ACC_W'(a) + rsfl_pkg::ACC_W'(b) + rsfl_pkg::ACC_W'(c) +
          rsfl_pkg::ACC_W'(d);
    avg = rsfl_pkg::RAW_W'(acc >> 2);
    p = ring_pos[s];
    ring_sum[s] = ring_sum[s] - 15'(ring[s][p]) + 15'(avg);
    ring[s][p] = avg;
    ring_pos[s] = p + 3'd1;
    filt = rsfl_pkg::RAW_W'(ring_sum[s] >> 3);
    raw_to_distance(int'(s), filt, dq, ok);
    r.filtered_raw = filt;
    r.distance_q8 = dq;
    r.distance_valid = ok;
    return r;
  endfunction

  task automatic clear_model();
    foreach (cal_pt[i]) cal_pt[i] = '0;
    cal_mask = '0;
    foreach (ring[s, k]) ring[s][k] = '0;
    foreach (ring_sum[s]) begin
      ring_sum[s] = '0;
      ring_pos[s] = '0;
    end
  endtask

  // push stays high between back-to-back words; an idle gap or a drain lowers it
  task automatic send_word(input logic [rsfl_pkg::SENSOR_W-1:0] s,
                           input logic [rsfl_pkg::RAW_W-1:0] a, b, c, d, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    sensor_index <= s;
    sample_a <= a;
    sample_b <= b;
    sample_c <= c;
    sample_d <= d;
    read_error <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    readings_due.push_back(filter_and_linearize(s, a, b, c, d, e));
    words_sent++;
  endtask

  task automatic check_reading();
    rsfl_pkg::result_t want, got;
    got.filtered_raw = filtered_raw;
    got.distance_q8 = distance_q8;
    got.distance_valid = distance_valid;
    got.read_failed = read_failed;
    if (readings_due.size() == 0) begin
      bad_readings++;
      if (bad_readings <= MAX_SHOWN)
        $display("unexpected word: raw=%0d dist=%0d valid=%0b err=%0b",
                 got.filtered_raw, got.distance_q8, got.distance_valid, got.read_failed);
    end else begin
      want = readings_due.pop_front();
      readings_checked++;
      if (want.filtered_raw !== got.filtered_raw || want.distance_q8 !== got.distance_q8 ||
          want.distance_valid !== got.distance_valid ||
          want.read_failed !== got.read_failed) begin
        bad_readings++;
        if (bad_readings <= MAX_SHOWN) begin
          $display("mismatch on word %0d: expected raw=%0d dist=%0d valid=%0b err=%0b",
                   readings_checked, want.filtered_raw, want.distance_q8,
                   want.distance_valid, want.read_failed);
          $display("  got raw=%0d dist=%0d valid=%0b err=%0b",
                   got.filtered_raw, got.distance_q8, got.distance_valid, got.read_failed);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_reading();
      pop <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycles, readings_due.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic drain();
    push <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rsfl_pkg::REG_W-1:0] idx,
                           input logic [rsfl_pkg::CAL_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx < rsfl_pkg::REG_CAL_VALID_MASK) cal_pt[idx] = val;
    else if (idx == rsfl_pkg::REG_CAL_VALID_MASK) cal_mask = val[rsfl_pkg::MASK_W-1:0];
  endtask

  task automatic apply_calibration(input logic [rsfl_pkg::MASK_W-1:0] mask);
    logic [rsfl_pkg::CAL_W-1:0] val;
    for (int i = 0; i < N_POINTS; i++)
      write_reg(rsfl_pkg::REG_CAL_POINT_0 + rsfl_pkg::REG_W'(i), next_cal[i]);
    // junk in the upper bits must be dropped
    val = rsfl_pkg::CAL_W'({$urandom, $urandom});
    val[rsfl_pkg::MASK_W-1:0] = mask;
    write_reg(rsfl_pkg::REG_CAL_VALID_MASK, val);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic set_points(input int s, input int p0, p1, p2, p3, p4, p5);
    next_cal[0][12*s +: 12] = 12'(p0);
    next_cal[1][12*s +: 12] = 12'(p1);
    next_cal[2][12*s +: 12] = 12'(p2);
    next_cal[3][12*s +: 12] = 12'(p3);
    next_cal[4][12*s +: 12] = 12'(p4);
    next_cal[5][12*s +: 12] = 12'(p5);
  endtask

  // mostly descending points; some flat and some inverted segments
  task automatic random_points(input int s);
    int lvl, dec;
    logic span_full;
    span_full = ($urandom_range(7) == 0);
    lvl = span_full ? 4095 : int'($urandom_range(1500, 4095));
    for (int i = 0; i < N_POINTS; i++) begin
      next_cal[i][12*s +: 12] = lvl[11:0];
      if ($urandom_range(5) == 0) dec = 0;
      else if ($urandom_range(9) == 0) dec = -int'($urandom_range(1, 400));
      else dec = int'($urandom_range(50, 800));
      lvl = lvl - dec;
      if (lvl < 0) lvl = 0;
      if (lvl > 4095) lvl = 4095;
    end
    if (span_full) next_cal[N_POINTS-1][12*s +: 12] = '0;
  endtask

  function automatic logic [rsfl_pkg::RAW_W-1:0] near(input int level, input int spread);
    int v;
    v = level + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  function automatic int pick_level(input int s);
    int sel;
    sel = int'($urandom_range(9));
    if (sel < 5) return int'(cal_raw_of(int'($urandom_range(N_POINTS - 1)), s)) +
                        int'($urandom_range(0, 40)) - 20;
    else if (sel == 5) return 0;
    else if (sel == 6) return 4095;
    return int'($urandom_range(4095));
  endfunction

  // bursts on one sensor settle the window near a level; a tenth is noise
  task automatic random_traffic(input int n_words);
    int done, s, level, burst, spread;
    done = 0;
    while (done < n_words) begin
      if ($urandom_range(9) == 0) begin
        send_word(2'($urandom_range(3)), 12'($urandom), 12'($urandom), 12'($urandom),
                  12'($urandom), 1'($urandom_range(1)));
        done++;
      end else begin
        s = int'($urandom_range(N_SENSORS - 1));
        level = pick_level(s);
        burst = int'($urandom_range(1, 12));
        spread = ($urandom_range(2) == 0) ? 0 : 8;
        for (int k = 0; k < burst; k++) begin
          send_word(2'(s), near(level, spread), near(level, spread), near(level, spread),
                    near(level, spread), $urandom_range(19) == 0);
          done++;
        end
      end
    end
  endtask

  task automatic test_uncalibrated();
    send_word(2'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0);
    send_word(2'd1, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    send_word(2'd3, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0);
    send_word(2'd2, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1);
    send_word(2'd3, 12'd1234, 12'd2345, 12'd3456, 12'd567, 1'b1);
  endtask

  task automatic test_calibration_edges();
    drain();
    write_reg(REG_OUT_OF_RANGE, '1);
    set_points(0, 3000, 2400, 1800, 1200, 800, 500);
    set_points(1, 4000, 4000, 2500, 1500, 900, 600);  // flat first segment
    set_points(2, 3500, 3000, 3200, 2000, 1000, 0);   // inverted second segment
    apply_calibration(3'b111);
    // sensor 1 ramps from below the last point up through all segments but the lowest, then overshoots the first point
    repeat (8) send_word(2'd1, 12'd4000, 12'd4000, 12'd4000, 12'd4000, 1'b0);
    send_word(2'd1, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0);
    send_word(2'd0, 12'd4095, 12'd4094, 12'd4094, 12'd4094, 1'b0);
    send_word(2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    send_word(2'd0, 12'd1, 12'd2, 12'd3, 12'd4, 1'b0);
    repeat (4) send_word(2'd2, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0);
  endtask

  task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n_words);
    drain();
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    for (int s = 0; s < N_SENSORS; s++) random_points(s);
    apply_calibration(($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'b111);
    random_traffic(n_words);
  endtask

  task automatic test_receiver_stall();
    int saved_pct;
    saved_pct = send_idle_pct;
    drain();
    send_idle_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    random_traffic(40);
    send_idle_pct = saved_pct;
  endtask

  task automatic test_full_scale_calibration();
    drain();
    foreach (next_cal[i]) next_cal[i] = '1;
    apply_calibration(3'b111);
    random_traffic(30);
  endtask

  initial begin
    clear_model();
    send_idle_pct = 35;
    recv_idle_pct = 84;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_uncalibrated();
    test_calibration_edges();
    test_random_phase(35, 84, 270);
    test_receiver_stall();
    test_random_phase(84, 35, 270);
    test_full_scale_calibration();
    test_random_phase(0, 0, 250);
    drain();
    $display("%0d words sent, %0d checked across %0d calibration settings,",
             words_sent, readings_checked, settings_used);
    $display("with idle gaps on both sides and one long output stall; %0d bad, %0d left due",
             bad_readings, readings_due.size());
    if (bad_readings == 0 && readings_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rsfl_pkg.sv
rtl/rsfl_fifo.sv
rtl/rsfl_ram.sv
rtl/rsfl_front.sv
rtl/rsfl_back.sv
rtl/range_sensor_filter_linearize.sv
sim/tb_top.sv
